/* rtl/rbs_pkg.sv */
package rbs_pkg;

    // Default coordinate format: signed Q16.16.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_DEPTH  = 3'd5;

    // Depth of the queues between the parts of the block.
    localparam int FIFO_DEPTH = 4;

endpackage

/* rtl/rbs_fifo.sv */
module rbs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_full,
    output logic         o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    // Pointers and fill level; the caller never pushes when full nor pops when empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rp];
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
endmodule

/* rtl/rbs_front.sv */
module rbs_front #(
    parameter int CW   = 32,
    parameter int FRAC = 16,
    parameter int NW   = CW + 2,
    parameter int AXW  = 2 * NW + CW + 2,
    parameter int IW   = 3 * AXW + CW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [rbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CW-1:0]                 i_cfg_data,
    input  logic signed [CW-1:0]          i_ray_origin_x,
    input  logic signed [CW-1:0]          i_ray_origin_y,
    input  logic signed [CW-1:0]          i_ray_origin_z,
    input  logic signed [CW-1:0]          i_ray_dir_x,
    input  logic signed [CW-1:0]          i_ray_dir_y,
    input  logic signed [CW-1:0]          i_ray_dir_z,
    input  logic signed [CW-1:0]          i_max_distance,
    output logic [IW-1:0]                 o_item
);
    localparam logic [CW-2:0] EXT_ONE = (CW-1)'(1) << FRAC;

    logic signed [CW-1:0] r_lo  [3];
    logic [CW-2:0]        r_ext [3];
    logic signed [CW-1:0] org   [3];
    logic signed [CW-1:0] dir   [3];

    // Box registers; to be written only while the block is idle, which the block itself does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a]  <= '0;
                r_ext[a] <= EXT_ONE;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rbs_pkg::REG_BOX_MIN_X:  r_lo[0]  <= i_cfg_data;
                rbs_pkg::REG_BOX_MIN_Y:  r_lo[1]  <= i_cfg_data;
                rbs_pkg::REG_BOX_MIN_Z:  r_lo[2]  <= i_cfg_data;
                rbs_pkg::REG_BOX_WIDTH:  r_ext[0] <= i_cfg_data[CW-2:0];
                rbs_pkg::REG_BOX_HEIGHT: r_ext[1] <= i_cfg_data[CW-2:0];
                rbs_pkg::REG_BOX_DEPTH:  r_ext[2] <= i_cfg_data[CW-2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        org[0] = i_ray_origin_x;
        org[1] = i_ray_origin_y;
        org[2] = i_ray_origin_z;
        dir[0] = i_ray_dir_x;
        dir[1] = i_ray_dir_y;
        dir[2] = i_ray_dir_z;
    end

    // Per axis: slab numerators, parallel flag and whether the origin is outside the slab.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [NW-1:0] lo_e, hi_e, o_e, nlo, nhi;
        logic                 par, outside;

        assign lo_e    = NW'(r_lo[a]);
        assign hi_e    = lo_e + $signed(NW'({1'b0, r_ext[a]}));
        assign o_e     = NW'(org[a]);
        assign nlo     = lo_e - o_e;
        assign nhi     = hi_e - o_e;
        assign par     = (dir[a] == '0);
        assign outside = (o_e < lo_e) || (o_e > hi_e);

        assign o_item[a*AXW +: AXW] = {outside, par, dir[a], nhi, nlo};
    end

    assign o_item[3*AXW +: CW] = i_max_distance;
endmodule

/* rtl/rbs_div.sv */
module rbs_div #(
    parameter int CW   = 32,
    parameter int FRAC = 16,
    parameter int NW   = CW + 2
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [CW-1:0] i_den,
    output logic signed [CW-1:0] o_quot
);
    // Dividend bits after the fractional shift; one quotient bit per stage.
    localparam int DW = NW + FRAC;

    logic [CW-1:0] r_ud  [DW+1];
    logic          r_neg [DW+1];
    logic [CW-1:0] r_rem [DW+1];
    logic [DW-1:0] r_dv  [DW+1];
    logic [DW-1:0] r_q   [DW+1];

    logic [NW-1:0] un;
    logic [CW-1:0] ud;

    assign un = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    assign ud = i_den[CW-1] ? CW'(-i_den) : CW'(i_den);

    // Entry stage: magnitudes and sign of the result.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ud[0]  <= ud;
            r_neg[0] <= i_num[NW-1] ^ i_den[CW-1];
            r_rem[0] <= '0;
            r_dv[0]  <= DW'(un) << FRAC;
            r_q[0]   <= '0;
        end
    end

    // Restoring long division, one bit per stage.
    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [CW:0] t, diff;
        logic        ge;

        assign t    = {r_rem[k], r_dv[k][DW-1]};
        assign ge   = (t >= {1'b0, r_ud[k]});
        assign diff = t - {1'b0, r_ud[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ud[k+1]  <= r_ud[k];
                r_neg[k+1] <= r_neg[k];
                r_rem[k+1] <= ge ? diff[CW-1:0] : t[CW-1:0];
                r_dv[k+1]  <= {r_dv[k][DW-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][DW-2:0], ge};
            end
        end
    end

    // Saturate to the signed coordinate range and apply the sign.
    logic          ovf;
    logic [CW-1:0] mag;

    assign ovf = |r_q[DW][DW-1:CW-1];
    assign mag = r_q[DW][CW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (ovf) begin
                o_quot <= r_neg[DW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            end else begin
                o_quot <= r_neg[DW] ? $signed(-mag) : $signed(mag);
            end
        end
    end
endmodule

/* rtl/rbs_back.sv */
module rbs_back #(
    parameter int CW   = 32,
    parameter int FRAC = 16,
    parameter int NW   = CW + 2,
    parameter int AXW  = 2 * NW + CW + 2,
    parameter int IW   = 3 * AXW + CW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [IW-1:0] i_item,
    output logic          o_valid,
    output logic          o_hit,
    output logic [CW-2:0] o_distance
);
    // Divider pipeline depth: entry stage, one stage per quotient bit, saturation stage.
    localparam int LAT = NW + FRAC + 2;
    localparam int SBW = CW + 6;

    logic signed [CW-1:0] q_lo [3];
    logic signed [CW-1:0] q_hi [3];
    logic [SBW-1:0]       sb_in;

    // Two dividers per axis: distances to the low and the high slab plane.
    for (genvar a = 0; a < 3; a++) begin : g_div
        rbs_div #(.CW(CW), .FRAC(FRAC), .NW(NW)) u_div_lo (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_num (i_item[a*AXW +: NW]),
            .i_den (i_item[a*AXW+2*NW +: CW]),
            .o_quot(q_lo[a])
        );
        rbs_div #(.CW(CW), .FRAC(FRAC), .NW(NW)) u_div_hi (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_num (i_item[a*AXW+NW +: NW]),
            .i_den (i_item[a*AXW+2*NW +: CW]),
            .o_quot(q_hi[a])
        );
        assign sb_in[a]     = i_item[a*AXW+2*NW+CW];
        assign sb_in[3 + a] = i_item[a*AXW+2*NW+CW+1];
    end
    assign sb_in[6 +: CW] = i_item[3*AXW +: CW];

    // Valid bits and side data travelling alongside the dividers.
    logic           r_sv [LAT];
    logic [SBW-1:0] r_sb [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) begin
                r_sv[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_sv[0] <= i_valid;
            for (int s = 1; s < LAT; s++) begin
                r_sv[s] <= r_sv[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb[0] <= sb_in;
            for (int s = 1; s < LAT; s++) begin
                r_sb[s] <= r_sb[s-1];
            end
        end
    end

    // Fold pipeline: index 0 holds the ordered distances, index k+1 has axis k applied.
    logic                 r_fv   [4];
    logic signed [CW-1:0] r_t1   [4][3];
    logic signed [CW-1:0] r_t2   [4][3];
    logic [2:0]           r_par  [4];
    logic [2:0]           r_out  [4];
    logic                 r_ns   [4];
    logic                 r_miss [4];
    logic signed [CW-1:0] r_tn   [4];
    logic signed [CW-1:0] r_tf   [4];

    // Put each axis pair in order and start the interval at the maximum distance.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_t1[0][a] <= (q_lo[a] > q_hi[a]) ? q_hi[a] : q_lo[a];
                r_t2[0][a] <= (q_lo[a] > q_hi[a]) ? q_lo[a] : q_hi[a];
            end
            r_par[0]  <= r_sb[LAT-1][2:0];
            r_out[0]  <= r_sb[LAT-1][5:3];
            r_ns[0]   <= 1'b0;
            r_miss[0] <= 1'b0;
            r_tn[0]   <= '0;
            r_tf[0]   <= r_sb[LAT-1][6 +: CW];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_fold
        logic                 ns, miss;
        logic signed [CW-1:0] tn, tf;

        // Narrow the interval by one axis; nothing changes once missed.
        always_comb begin
            ns   = r_ns[k];
            miss = r_miss[k];
            tn   = r_tn[k];
            tf   = r_tf[k];
            if (!r_miss[k]) begin
                if (r_par[k][k]) begin
                    miss = r_out[k][k];
                end else begin
                    if (!r_ns[k] || (r_t1[k][k] > r_tn[k])) begin
                        tn = r_t1[k][k];
                        ns = 1'b1;
                    end
                    if (r_t2[k][k] < r_tf[k]) begin
                        tf = r_t2[k][k];
                    end
                    if (tn > tf) begin
                        miss = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t1[k+1]   <= r_t1[k];
                r_t2[k+1]   <= r_t2[k];
                r_par[k+1]  <= r_par[k];
                r_out[k+1]  <= r_out[k];
                r_ns[k+1]   <= ns;
                r_miss[k+1] <= miss;
                r_tn[k+1]   <= tn;
                r_tf[k+1]   <= tf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 4; s++) begin
                r_fv[s] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_fv[0] <= r_sv[LAT-1];
            for (int s = 1; s < 4; s++) begin
                r_fv[s] <= r_fv[s-1];
            end
            o_valid <= r_fv[3];
        end
    end

    // Final decision: behind the origin is a miss; report the nearest usable distance.
    logic                 fmiss;
    logic signed [CW-1:0] d;

    assign fmiss = r_miss[3] || (r_tf[3] < 0);
    assign d     = (r_ns[3] && (r_tn[3] >= 0)) ? r_tn[3] : r_tf[3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit      <= !fmiss;
            o_distance <= fmiss ? '0 : d[CW-2:0];
        end
    end
endmodule

/* rtl/ray_box_slab_intersect.sv */
// Ray against axis-aligned box, slab method, one ray per transaction.
// Input channel: drive the ray fields and raise i_push; the transaction is
// taken at a clock edge where i_push is high and o_full is low.
// Result channel: while o_empty is low the oldest result sits on o_hit and
// o_distance; raising i_pop takes it at the next edge.
// Configuration channel: i_cfg_valid with i_cfg_index and i_cfg_data; o_cfg_ready
// is always high. Write only while no ray is in flight.
// The dividers are bit-per-stage pipelines; the default format is signed Q16.16.
// Throughput is one ray per cycle while the result queue lets the pipeline
// advance; six dividers work on every ray at once.
// A short queue sits between the classifying front end and the divider
// pipeline, and another holds finished results. When the result queue is
// full and not being popped, the whole divider pipeline holds; the front
// queue then fills and o_full rises. Nothing is lost or repeated.
// Synchronous active-low reset empties both queues and the pipeline and
// sets the box to the unit cube at the origin.
module ray_box_slab_intersect #(
    parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic signed [COORD_WIDTH-1:0] i_ray_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_ray_origin_y,
    input  logic signed [COORD_WIDTH-1:0] i_ray_origin_z,
    input  logic signed [COORD_WIDTH-1:0] i_ray_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_ray_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_ray_dir_z,
    input  logic signed [COORD_WIDTH-1:0] i_max_distance,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_hit,
    output logic [COORD_WIDTH-2:0]        o_distance
);
    localparam int CW  = COORD_WIDTH;
    localparam int NW  = CW + 2;
    localparam int AXW = 2 * NW + CW + 2;
    localparam int IW  = 3 * AXW + CW;

    logic [IW-1:0] item, mid_item;
    logic          mid_push, mid_pop, mid_full, mid_empty;
    logic          en, back_valid, back_hit, out_full;
    logic [CW-2:0] back_dist;
    logic [CW-1:0] out_data;

    assign o_cfg_ready = 1'b1;

    // Front end: box registers and per-axis classification.
    rbs_front #(.CW(CW), .FRAC(FRAC_BITS), .NW(NW), .AXW(AXW), .IW(IW)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_ray_origin_x(i_ray_origin_x),
        .i_ray_origin_y(i_ray_origin_y),
        .i_ray_origin_z(i_ray_origin_z),
        .i_ray_dir_x   (i_ray_dir_x),
        .i_ray_dir_y   (i_ray_dir_y),
        .i_ray_dir_z   (i_ray_dir_z),
        .i_max_distance(i_max_distance),
        .o_item        (item)
    );

    // Queue between the front end and the divider pipeline.
    assign mid_push = i_push && !mid_full;
    assign o_full   = mid_full;

    rbs_fifo #(.W(IW), .DEPTH(rbs_pkg::FIFO_DEPTH)) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (mid_push),
        .i_wdata(item),
        .i_pop  (mid_pop),
        .o_rdata(mid_item),
        .o_full (mid_full),
        .o_empty(mid_empty)
    );

    // The pipeline advances whenever the result queue can take its output.
    assign en      = !out_full || i_pop;
    assign mid_pop = en && !mid_empty;

    rbs_back #(.CW(CW), .FRAC(FRAC_BITS), .NW(NW), .AXW(AXW), .IW(IW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (!mid_empty),
        .i_item    (mid_item),
        .o_valid   (back_valid),
        .o_hit     (back_hit),
        .o_distance(back_dist)
    );

    // Result queue.
    rbs_fifo #(.W(CW), .DEPTH(rbs_pkg::FIFO_DEPTH)) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (back_valid && en),
        .i_wdata({back_hit, back_dist}),
        .i_pop  (i_pop && !o_empty),
        .o_rdata(out_data),
        .o_full (out_full),
        .o_empty(o_empty)
    );

    assign o_hit      = out_data[CW-1];
    assign o_distance = out_data[CW-2:0];

`ifndef SYNTHESIS
    // Reset leaves both channels empty and open.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not empty after reset");

    // A stalled pipeline holds the valid bit of its finished result.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_full && !i_pop) |=> $stable(back_valid))
        else $error("pipeline moved while stalled");

    // A waiting result is not dropped unless popped.
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> !o_empty)
        else $error("result lost");

    // The front queue only drains while the pipeline advances.
    a_mid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!mid_empty && !en && !i_push) |=> !mid_empty)
        else $error("front queue drained while stalled");
`endif
endmodule

/* sim/ray_box_slab_intersect_tb.sv */
`timescale 1ns / 100ps

module ray_box_slab_intersect_tb;

    localparam int CW       = 32;
    localparam int FB       = 16;
    localparam int LATENCY  = CW + FB + 10;
    localparam int WD_LIMIT = 20000;

    typedef struct {
        logic signed [CW-1:0] org [3];
        logic signed [CW-1:0] dir [3];
        logic signed [CW-1:0] tmax;
    } ray_t;

    typedef struct {
        logic          hit;
        logic [CW-2:0] distance;
    } answer_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [rbs_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CW-1:0]                 i_cfg_data = '0;
    logic                          i_push = 1'b0;
    logic                          o_full;
    logic signed [CW-1:0]          i_ray_origin_x = '0;
    logic signed [CW-1:0]          i_ray_origin_y = '0;
    logic signed [CW-1:0]          i_ray_origin_z = '0;
    logic signed [CW-1:0]          i_ray_dir_x = '0;
    logic signed [CW-1:0]          i_ray_dir_y = '0;
    logic signed [CW-1:0]          i_ray_dir_z = '0;
    logic signed [CW-1:0]          i_max_distance = '0;
    logic                          o_empty;
    logic                          i_pop = 1'b0;
    logic                          o_hit;
    logic [CW-2:0]                 o_distance;

    // Predictor copy of the box registers.
    longint box_lo [3];
    longint box_ext [3];

    answer_t expected_answers [$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    bit      pop_enable = 1'b0;
    bit      hold_off = 1'b0;

    ray_box_slab_intersect dut (.*);

    always #10 i_clk = ~i_clk;

    // Fixed-point quotient, truncated toward zero and saturated to 32 bits.
    function automatic longint slab_quotient(longint num, longint den);
        longint q;
        q = (num * 65536) / den;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    function automatic answer_t predict_hit(ray_t r);
        answer_t a;
        longint  tnear, tfar, hi, t1, t2, o, d, sel;
        bit      near_set, miss;
        tnear = 0;
        near_set = 1'b0;
        miss = 1'b0;
        tfar = longint'(r.tmax);
        for (int i = 0; i < 3; i++) begin
            if (!miss) begin
                o = longint'(r.org[i]);
                d = longint'(r.dir[i]);
                hi = box_lo[i] + box_ext[i];
                if (d == 0) begin
                    if (o < box_lo[i] || o > hi) miss = 1'b1;
                end else begin
                    t1 = slab_quotient(box_lo[i] - o, d);
                    t2 = slab_quotient(hi - o, d);
                    if (t1 > t2) begin
                        sel = t1; t1 = t2; t2 = sel;
                    end
                    if (!near_set || t1 > tnear) begin
                        tnear = t1;
                        near_set = 1'b1;
                    end
                    if (t2 < tfar) tfar = t2;
                    if (tnear > tfar) miss = 1'b1;
                end
            end
        end
        if (!miss && tfar < 0) miss = 1'b1;
        a.hit = !miss;
        a.distance = '0;
        if (!miss) begin
            sel = (near_set && tnear >= 0) ? tnear : tfar;
            a.distance = sel[CW-2:0];
        end
        return a;
    endfunction

    // Register write; the block must be idle. The caller drops valid afterwards.
    task automatic write_box_reg(logic [rbs_pkg::CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rbs_pkg::REG_BOX_MIN_X:  box_lo[0] = longint'($signed(val));
            rbs_pkg::REG_BOX_MIN_Y:  box_lo[1] = longint'($signed(val));
            rbs_pkg::REG_BOX_MIN_Z:  box_lo[2] = longint'($signed(val));
            rbs_pkg::REG_BOX_WIDTH:  box_ext[0] = longint'(val[CW-2:0]);
            rbs_pkg::REG_BOX_HEIGHT: box_ext[1] = longint'(val[CW-2:0]);
            rbs_pkg::REG_BOX_DEPTH:  box_ext[2] = longint'(val[CW-2:0]);
            default: ;
        endcase
    endtask

    task automatic set_box(logic [CW-1:0] mx, my, mz, w, h, dp);
        write_box_reg(rbs_pkg::REG_BOX_MIN_X, mx);
        write_box_reg(rbs_pkg::REG_BOX_MIN_Y, my);
        write_box_reg(rbs_pkg::REG_BOX_MIN_Z, mz);
        write_box_reg(rbs_pkg::REG_BOX_WIDTH, w);
        write_box_reg(rbs_pkg::REG_BOX_HEIGHT, h);
        write_box_reg(rbs_pkg::REG_BOX_DEPTH, dp);
        i_cfg_valid <= 1'b0;
    endtask

    // Stops offering rays and waits until every result has been taken.
    task automatic wait_drained();
        i_push <= 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Offers one ray, with an optional random gap first.
    task automatic send_ray(ray_t r, bit gaps);
        int g;
        if (gaps) begin
            g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                             : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) g = 0;
            if (g > 0) begin
                i_push <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
        i_push <= 1'b1;
        i_ray_origin_x <= r.org[0];
        i_ray_origin_y <= r.org[1];
        i_ray_origin_z <= r.org[2];
        i_ray_dir_x <= r.dir[0];
        i_ray_dir_y <= r.dir[1];
        i_ray_dir_z <= r.dir[2];
        i_max_distance <= r.tmax;
        do @(posedge i_clk); while (o_full);
        expected_answers.push_back(predict_hit(r));
    endtask

    function automatic ray_t make_ray(longint ox, oy, oz, dx, dy, dz, tm);
        ray_t r;
        r.org[0] = CW'(ox); r.org[1] = CW'(oy); r.org[2] = CW'(oz);
        r.dir[0] = CW'(dx); r.dir[1] = CW'(dy); r.dir[2] = CW'(dz);
        r.tmax = CW'(tm);
        return r;
    endfunction

    function automatic logic [CW-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return $urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // A ray from a point near the box's minimum corner, so that hits are common.
    function automatic ray_t aimed_ray();
        ray_t r;
        for (int i = 0; i < 3; i++) begin
            r.org[i] = CW'(box_lo[i] + longint'($urandom_range(0, 6 * 65536)) - 3 * 65536);
            case ($urandom_range(0, 5))
                0: r.dir[i] = '0;
                1: r.dir[i] = $signed($urandom_range(0, 3)) - 2;
                default: r.dir[i] = $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
            endcase
        end
        case ($urandom_range(0, 3))
            0: r.tmax = 32'h7fff_ffff;
            1: r.tmax = -$signed($urandom_range(0, 65536));
            default: r.tmax = $urandom_range(0, 16 * 65536);
        endcase
        return r;
    endfunction

    function automatic ray_t noise_ray();
        ray_t r;
        for (int i = 0; i < 3; i++) begin
            r.org[i] = rand_word();
            r.dir[i] = rand_word();
        end
        r.tmax = rand_word();
        return r;
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        answer_t e;
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result hit=%0b distance=%0h", o_hit, o_distance);
            end else begin
                e = expected_answers.pop_front();
                if (o_hit !== e.hit || o_distance !== e.distance) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit=%0b distance=%0h, %s",
                                 e.hit, e.distance,
                                 $sformatf("got hit=%0b distance=%0h", o_hit, o_distance));
                end
            end
        end
    end

    // Receiver stalls.
    always @(posedge i_clk) begin
        if (!pop_enable || hold_off) i_pop <= 1'b0;
        else if ($urandom_range(0, 29) == 0) i_pop <= 1'b0;
        else i_pop <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end

    // Watchdog on transactions.
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || i_cfg_valid || !pop_enable)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_corner_cases();
        ray_t r;
        send_ray(make_ray(-65536, 32768, 32768, 65536, 0, 0, 32'h7fff_ffff), 0);
        send_ray(make_ray(32768, 32768, 32768, 65536, 65536, 65536, 32'h7fff_ffff), 0);
        send_ray(make_ray(32768, 32768, 32768, 0, 0, 0, 5 * 65536), 0);
        send_ray(make_ray(32768, 32768, 32768, 0, 0, 0, -1), 0);
        send_ray(make_ray(2 * 65536, 32768, 32768, 0, 0, 0, 65536), 0);
        send_ray(make_ray(-65536, 32768, 32768, -65536, 0, 0, 32'h7fff_ffff), 0);
        send_ray(make_ray(-65536, 32768, 32768, 65536, 0, 0, 32768), 0);
        send_ray(make_ray(-65536, -65536, 32768, 65536, 4 * 65536, 0, 32'h7fff_ffff), 0);
        send_ray(make_ray(32'h8000_0000, 32768, 32768, 1, 0, 0, 32'h7fff_ffff), 0);
        send_ray(make_ray(32'h7fff_ffff, 32768, 32768, 32'h8000_0000, 0, 0,
                          32'h7fff_ffff), 0);
        send_ray(make_ray(32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff,
                          32'h8000_0000, 32'hffff_ffff, 32'h8000_0000), 0);
        send_ray(make_ray(0, 0, 0, -1, 1, -1, 0), 0);
        send_ray(make_ray(65536, 65536, 65536, 0, 0, 0, 0), 0);
        r = make_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                     32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_ray(r, 0);
        wait_drained();
    endtask

    task automatic test_random_rays(int n);
        for (int k = 0; k < n; k++)
            send_ray(($urandom_range(0, 4) == 0) ? noise_ray() : aimed_ray(), 1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (LATENCY + 150) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 90; k++) send_ray(aimed_ray(), 0);
        join
        wait_drained();
    endtask

    initial begin
        box_lo = '{0, 0, 0};
        box_ext = '{65536, 65536, 65536};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        pop_enable = 1'b1;

        test_corner_cases();
        test_random_rays(120);
        test_backpressure();

        set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        test_corner_cases();
        test_random_rays(80);

        set_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0);
        test_random_rays(60);

        set_box(-3 * 65536, 2 * 65536, 0, 5 * 65536, 32768, 3 * 65536);
        test_random_rays(120);

        set_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        test_random_rays(60);

        wait_drained();
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
